[hdl/dlpg_pkg.sv]
// Shared constants, types and helpers for the DDA line point generator.
package dlpg_pkg;

  localparam int TILE_SIZE   = 64;
  localparam int COORD_BITS  = 6;
  localparam int FRAC_BITS   = 16;
  localparam int FIX_W       = COORD_BITS + FRAC_BITS;
  localparam int SLOPE_W     = FRAC_BITS + 2;
  localparam int QUOT_W      = FRAC_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(QUOT_W);
  localparam int REM_W       = COORD_BITS + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FIX_W-1:0]      fix_t;
  typedef logic [SLOPE_W-1:0]    slope_t;

  // One classified segment, handed from front end to back end.
  typedef struct packed {
    logic   axis_x;
    coord_t maj0;
    coord_t maj1;
    coord_t min0;
    slope_t slope;
  } job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_e;

  function automatic coord_t clip_coord(input coord_t v);
    coord_t c;
    c = v;
    if (c > COORD_BITS'(TILE_SIZE - 1)) begin
      c = COORD_BITS'(TILE_SIZE - 1);
    end
    return c;
  endfunction

endpackage

[hdl/dda_line_point_generator.sv]
// Top level of the DDA line point generator.
//
// channel   direction  handshake           beat
// segment   in         start_i, busy_o     start/end x,y (6-bit pixels)
// point     out        valid_o (no ready)  point_x/y (6.16), major_is_x, last
//
// A segment is taken when start_i is high and busy_o low; busy_o then stays
// high through the 17 slope division steps and the push into the queue, and
// longer while the two-entry job queue is full. The stepper emits one point per
// cycle, |dmajor|+1 points per segment, and the front end can divide the next
// segment meanwhile. The first point follows once the job has passed the queue.
// Reset clears the FSM, queue pointers and active flag; point beats can't stall.
module dda_line_point_generator import dlpg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  output logic   busy_o,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  output logic   valid_o,
  output fix_t   point_x_o,
  output fix_t   point_y_o,
  output logic   major_is_x_o,
  output logic   last_o
);

  logic push, q_full, pop, q_empty;
  job_t fe_job, be_job;

  dlpg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .busy_o    (busy_o),
    .q_full_i  (q_full),
    .push_o    (push),
    .job_o     (fe_job)
  );

  dlpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (fe_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (be_job)
  );

  dlpg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .job_i        (be_job),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .major_is_x_o (major_is_x_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  a_major_frac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (major_is_x_o ? (point_x_o[FRAC_BITS-1:0] == '0)
                              : (point_y_o[FRAC_BITS-1:0] == '0)))
    else $error("major coordinate has a nonzero fraction");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job queue written while full");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("front end not busy after accepting a segment");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("back end popped an empty queue");
`endif

endmodule

[hdl/dlpg_front.sv]
// Front end: classifies a segment and divides out its slope one bit per cycle.
module dlpg_front import dlpg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  output logic   busy_o,
  input  logic   q_full_i,
  output logic   push_o,
  output job_t   job_o
);

  fe_state_e state_q, state_d;
  job_t      job_q;
  coord_t    dmaj_q;
  logic      neg_q;
  logic [REM_W-1:0]     rem_q;
  logic [QUOT_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  coord_t sx, sy, ex, ey;
  logic [COORD_BITS:0] dx, dy, dmin;
  coord_t adx, ady, amin;
  coord_t maj0, maj1, min0, min1, tmaj0, tmaj1, tmin0, tmin1;
  logic   axis_x, accept, rem_ge;
  logic [REM_W-1:0] rem_sub;
  logic [QUOT_W-1:0] quo_sel;
  slope_t slope_mag;

  assign accept = start_i && (state_q == FE_IDLE);

  always_comb begin
    sx = clip_coord(start_x_i);
    sy = clip_coord(start_y_i);
    ex = clip_coord(end_x_i);
    ey = clip_coord(end_y_i);
    dx = {1'b0, ex} - {1'b0, sx};
    dy = {1'b0, ey} - {1'b0, sy};
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    axis_x = adx > ady;
    tmaj0 = axis_x ? sx : sy;
    tmaj1 = axis_x ? ex : ey;
    tmin0 = axis_x ? sy : sx;
    tmin1 = axis_x ? ey : ex;
    if (tmaj0 > tmaj1) begin
      maj0 = tmaj1; maj1 = tmaj0; min0 = tmin1; min1 = tmin0;
    end else begin
      maj0 = tmaj0; maj1 = tmaj1; min0 = tmin0; min1 = tmin1;
    end
    dmin = {1'b0, min1} - {1'b0, min0};
    amin = dmin[COORD_BITS] ? COORD_BITS'(-dmin) : dmin[COORD_BITS-1:0];
  end

  // Restoring division of |dmin| * 2^FRAC_BITS by dmaj; |dmin| <= dmaj.
  assign rem_ge  = rem_q >= {1'b0, dmaj_q};
  assign rem_sub = rem_ge ? (rem_q - {1'b0, dmaj_q}) : rem_q;

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    unique case (state_q)
      FE_IDLE: if (start_i) state_d = FE_DIV;
      FE_DIV:  if (cnt_q == '0) state_d = FE_PUSH;
      FE_PUSH: begin
        push_o = !q_full_i;
        if (!q_full_i) state_d = FE_IDLE;
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // Zero-length segment: divisor is zero, slope forced to zero.
  assign quo_sel   = (dmaj_q == '0) ? '0 : quo_q;
  assign slope_mag = {1'b0, quo_sel};

  always_comb begin
    job_o = job_q;
    job_o.slope = neg_q ? slope_t'(-slope_mag) : slope_mag;
  end

  assign busy_o = state_q != FE_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.axis_x <= axis_x;
      job_q.maj0   <= maj0;
      job_q.maj1   <= maj1;
      job_q.min0   <= min0;
      job_q.slope  <= '0;
      dmaj_q       <= maj1 - maj0;
      neg_q        <= dmin[COORD_BITS];
      rem_q        <= {1'b0, amin};
      quo_q        <= '0;
      cnt_q        <= DIV_CNT_W'(QUOT_W - 1);
    end else if (state_q == FE_DIV) begin
      rem_q <= {rem_sub[REM_W-2:0], 1'b0};
      quo_q <= {quo_q[QUOT_W-2:0], rem_ge};
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[hdl/dlpg_queue.sv]
// Short job queue between the front and back ends.
module dlpg_queue import dlpg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

endmodule

[hdl/dlpg_back.sv]
// Back end: steps the major axis and accumulates the minor coordinate.
module dlpg_back import dlpg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  job_t job_i,
  output logic pop_o,
  output logic valid_o,
  output fix_t point_x_o,
  output fix_t point_y_o,
  output logic major_is_x_o,
  output logic last_o
);

  logic   active_q;
  coord_t pos_q, end_q;
  fix_t   acc_q;
  slope_t slope_q;
  logic   axis_q;
  logic   fin;
  fix_t   maj_fix;

  assign fin     = pos_q >= end_q;
  // next segment loads in the same cycle the final point goes out
  assign pop_o   = (!active_q || fin) && !q_empty_i;
  assign maj_fix = {pos_q, FRAC_BITS'(0)};

  assign valid_o      = active_q;
  assign point_x_o    = axis_q ? maj_fix : acc_q;
  assign point_y_o    = axis_q ? acc_q : maj_fix;
  assign major_is_x_o = axis_q;
  assign last_o       = fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (pop_o) begin
      active_q <= 1'b1;
    end else if (fin) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pos_q   <= job_i.maj0;
      end_q   <= job_i.maj1;
      acc_q   <= {job_i.min0, FRAC_BITS'(0)};
      slope_q <= job_i.slope;
      axis_q  <= job_i.axis_x;
    end else if (active_q && !fin) begin
      pos_q <= pos_q + 1'b1;
      acc_q <= acc_q + {{(FIX_W - SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
    end
  end

endmodule
